FILE: hdl/fcph_pkg.sv
// fan curve controller package: register indexes, field widths and fixed constants
// no dependencies; imported by fan_curve_pwm_hysteresis_top
`default_nettype none

package fcph_pkg;

  // field and register widths
  localparam int TempMilliW = 19;
  localparam int TempCfgW   = 9;
  localparam int DutyW      = 8;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 9;

  // millidegrees per whole degree
  localparam int MilliPerDeg = 1000;

  // internal datapath widths, sized for the full range of the fields
  localparam int DiffW    = 21;  // sample minus scaled low temperature
  localparam int DenW     = 20;  // scaled temperature span
  localparam int NumW     = 30;  // signed numerator of the curve
  localparam int DivBits  = 30;  // dividend width, one quotient bit per cycle
  localparam int RemW     = 20;  // remainder and divisor width
  localparam int DivCntW  = 5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTempLow    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTempHigh   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDutyFloor  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDutyCeil   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDutyStart  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDutyStop   = 3'd5;

  // register reset values
  localparam logic signed [TempCfgW-1:0] RstTempLow   = 9'sd40;
  localparam logic signed [TempCfgW-1:0] RstTempHigh  = 9'sd80;
  localparam logic [DutyW-1:0]           RstDutyFloor = 8'd0;
  localparam logic [DutyW-1:0]           RstDutyCeil  = 8'd255;
  localparam logic [DutyW-1:0]           RstDutyStart = 8'd100;
  localparam logic [DutyW-1:0]           RstDutyStop  = 8'd60;

endpackage

`default_nettype wire

FILE: hdl/fan_curve_pwm_hysteresis_top.sv
// Linear fan curve with start/stop hysteresis, one duty result per temperature sample.
// One sample in flight: it passes PREP, MUL, SETUP and the restoring divider, which retires
// one quotient bit per cycle over 30 bits, then FIN (the divider is skipped when the two curve
// temperatures are equal); FIN holds the result until the output register is free.
// The next sample is taken while a finished result still waits on the output register.
// Reset (rst_n low, synchronous): registers to defaults, fan running. Depends on fcph_pkg.
`default_nettype none

module fan_curve_pwm_hysteresis_top
  import fcph_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration write port
  input  wire logic                        cfg_we,
  input  wire logic [CfgIdxW-1:0]          cfg_index,
  input  wire logic [CfgDataW-1:0]         cfg_wdata,
  // temperature sample channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [TempMilliW-1:0] in_temp_milli,
  // duty result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [DutyW-1:0]                 out_pwm_duty,
  output logic                             out_fan_stopped
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_SETUP,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state_r;

  // configuration registers
  logic signed [TempCfgW-1:0] temp_low_r;
  logic signed [TempCfgW-1:0] temp_high_r;
  logic [DutyW-1:0]           duty_floor_r;
  logic [DutyW-1:0]           duty_ceil_r;
  logic [DutyW-1:0]           duty_start_r;
  logic [DutyW-1:0]           duty_stop_r;

  // hysteresis state
  logic stopped_r;

  // datapath registers
  logic signed [TempMilliW-1:0] temp_r;
  logic signed [DiffW-1:0]      diff_r;
  logic signed [DenW-1:0]       den_r;
  logic                         den_zero_r;
  logic signed [NumW-1:0]       num_r;
  logic                         neg_r;
  logic [DivBits-1:0]           work_r;
  logic [RemW-1:0]              rem_r;
  logic [RemW-1:0]              div_r;
  logic [DivCntW-1:0]           cnt_r;

  // output register
  logic             out_valid_r;
  logic [DutyW-1:0] out_pwm_duty_r;
  logic             out_fan_stopped_r;

  // prep stage: offset from curve start and scaled temperature span
  logic signed [DiffW-1:0] lo_m;
  logic signed [DiffW-1:0] diff_nxt;
  logic signed [DenW-1:0]  span;
  logic signed [DenW-1:0]  den_nxt;

  assign lo_m     = DiffW'(temp_low_r) * DiffW'(MilliPerDeg);
  assign diff_nxt = DiffW'(temp_r) - lo_m;
  assign span     = DenW'(temp_high_r) - DenW'(temp_low_r);
  assign den_nxt  = span * DenW'(MilliPerDeg);

  // multiply stage: numerator = diff * (ceil - start) + start * den
  logic signed [DutyW+1:0] duty_delta;
  logic signed [NumW:0]    prod_slope;
  logic signed [NumW:0]    prod_start;
  logic signed [NumW-1:0]  num_nxt;

  assign duty_delta = $signed({2'b00, duty_ceil_r}) - $signed({2'b00, duty_start_r});
  assign prod_slope = (NumW+1)'(diff_r) * (NumW+1)'(duty_delta);
  assign prod_start = (NumW+1)'($signed({1'b0, duty_start_r})) * (NumW+1)'(den_r);
  assign num_nxt    = NumW'(prod_slope + prod_start);

  // setup stage: magnitudes and rounding offset, (2|n| + |d|) / (2|d|)
  logic [NumW-1:0]    abs_num;
  logic [DenW-1:0]    abs_den;
  logic [DivBits-1:0] dividend_nxt;
  logic [RemW-1:0]    divisor_nxt;
  logic               neg_nxt;
  logic [DutyW-1:0]   step_val;

  assign abs_num      = num_r[NumW-1] ? $unsigned(NumW'(-num_r)) : $unsigned(num_r);
  assign abs_den      = den_r[DenW-1] ? $unsigned(DenW'(-den_r)) : $unsigned(den_r);
  assign dividend_nxt = {abs_num[DivBits-2:0], 1'b0} + DivBits'(abs_den);
  assign divisor_nxt  = {abs_den[RemW-2:0], 1'b0};
  assign neg_nxt      = num_r[NumW-1] ^ den_r[DenW-1];
  assign step_val     = (diff_r >= 0) ? duty_ceil_r : duty_floor_r;

  // divider step: shift in one dividend bit, subtract when it fits
  logic [RemW:0]   trial;
  logic [RemW:0]   trial_sub;
  logic            fits;
  logic [RemW-1:0] rem_nxt;

  assign trial     = {rem_r, work_r[DivBits-1]};
  assign trial_sub = trial - {1'b0, div_r};
  assign fits      = (trial >= {1'b0, div_r});
  assign rem_nxt   = fits ? trial_sub[RemW-1:0] : trial[RemW-1:0];

  // clamp of the signed mapped value
  logic             val_neg;
  logic             val_big;
  logic             below_floor;
  logic             above_ceil;
  logic [DutyW-1:0] clamped;

  assign val_neg     = neg_r && (work_r != '0);
  assign val_big     = (work_r[DivBits-1:DutyW] != '0);
  assign below_floor = val_neg || (!val_big && (work_r[DutyW-1:0] < duty_floor_r));
  assign above_ceil  = !val_neg && (val_big || (work_r[DutyW-1:0] > duty_ceil_r));
  assign clamped     = below_floor ? duty_floor_r :
                       above_ceil  ? duty_ceil_r  : work_r[DutyW-1:0];

  // start/stop hysteresis
  logic             stopped_nxt;
  logic [DutyW-1:0] duty_nxt;

  always_comb begin
    stopped_nxt = stopped_r;
    duty_nxt    = clamped;
    if (stopped_r) begin
      if (clamped < duty_start_r) begin
        duty_nxt = '0;
      end else begin
        stopped_nxt = 1'b0;
      end
    end
    if (!stopped_nxt && (duty_nxt <= duty_stop_r)) begin
      duty_nxt    = '0;
      stopped_nxt = 1'b1;
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      temp_low_r   <= RstTempLow;
      temp_high_r  <= RstTempHigh;
      duty_floor_r <= RstDutyFloor;
      duty_ceil_r  <= RstDutyCeil;
      duty_start_r <= RstDutyStart;
      duty_stop_r  <= RstDutyStop;
      stopped_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CfgTempLow:   temp_low_r   <= $signed(cfg_wdata[TempCfgW-1:0]);
          CfgTempHigh:  temp_high_r  <= $signed(cfg_wdata[TempCfgW-1:0]);
          CfgDutyFloor: duty_floor_r <= cfg_wdata[DutyW-1:0];
          CfgDutyCeil:  duty_ceil_r  <= cfg_wdata[DutyW-1:0];
          CfgDutyStart: duty_start_r <= cfg_wdata[DutyW-1:0];
          CfgDutyStop:  duty_stop_r  <= cfg_wdata[DutyW-1:0];
          default: ;
        endcase
      end

      // result transaction taken downstream
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            temp_r  <= in_temp_milli;
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          diff_r     <= diff_nxt;
          den_r      <= den_nxt;
          den_zero_r <= (temp_high_r == temp_low_r);
          state_r    <= ST_MUL;
        end
        ST_MUL: begin
          num_r   <= num_nxt;
          state_r <= ST_SETUP;
        end
        ST_SETUP: begin
          rem_r <= '0;
          cnt_r <= '0;
          if (den_zero_r) begin
            // equal temperatures: step between floor and ceiling
            work_r  <= DivBits'(step_val);
            neg_r   <= 1'b0;
            state_r <= ST_FIN;
          end else begin
            work_r  <= dividend_nxt;
            div_r   <= divisor_nxt;
            neg_r   <= neg_nxt;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r  <= rem_nxt;
          work_r <= {work_r[DivBits-2:0], fits};
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == DivCntW'(DivBits - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_pwm_duty_r    <= duty_nxt;
            out_fan_stopped_r <= stopped_nxt;
            stopped_r         <= stopped_nxt;
            state_r           <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_pwm_duty    = out_pwm_duty_r;
  assign out_fan_stopped = out_fan_stopped_r;

`ifndef SYNTHESIS
  // partial remainder always stays below the divisor
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  // divider never runs past the dividend width
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r < DivCntW'(DivBits)))
    else $error("divider count out of range");

  // a stopped fan is never driven
  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fan_stopped_r) |-> (out_pwm_duty_r == '0))
    else $error("nonzero duty reported with fan stopped");

  // reported flag tracks the hysteresis state while the result waits
  a_flag_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fan_stopped_r == stopped_r))
    else $error("reported stop flag differs from state");

  // a finished result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_ready) |=> (state_r == ST_FIN))
    else $error("result left while output register busy");
`endif

endmodule

`default_nettype wire
